@@ rtl/kvt_pkg.sv @@
// Package for the key/value table: sizes, operation and status codes,
// and the word types passed along the cell chain and the insert bus.
// No dependencies.
package kvt_pkg;

    // Table sizes.
    localparam int KVT_ENTRIES    = 16;
    localparam int KVT_KEY_BITS   = 64;
    localparam int KVT_VALUE_BITS = 64;
    localparam int KVT_IDX_W      = $clog2(KVT_ENTRIES);

    // Port field widths.
    localparam int KVT_FUNC_W   = 2;
    localparam int KVT_KEY_W    = 64;
    localparam int KVT_VALUE_W  = 64;
    localparam int KVT_STATUS_W = 3;

    typedef enum logic [KVT_FUNC_W-1:0] {
        FN_GET     = 2'd0,
        FN_PUT     = 2'd1,
        FN_DELETE  = 2'd2,
        FN_UNKNOWN = 2'd3
    } t_func;

    typedef enum logic [KVT_STATUS_W-1:0] {
        ST_FOUND     = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_INSERTED  = 3'd2,
        ST_DELETED   = 3'd3,
        ST_FULL      = 3'd4,
        ST_UNKNOWN   = 3'd5
    } t_status;

    // Request word as it walks the chain, with the search results so far.
    typedef struct packed {
        logic                      vld;
        t_func                     func;
        logic [KVT_KEY_BITS-1:0]   key;
        logic [KVT_VALUE_BITS-1:0] value;
        logic                      hit;
        logic [KVT_VALUE_BITS-1:0] rd;
        logic                      free_found;
        logic [KVT_IDX_W-1:0]      free_idx;
    } t_tok;

    // Insert command broadcast to all cells.
    typedef struct packed {
        logic                      en;
        logic [KVT_IDX_W-1:0]      idx;
        logic [KVT_KEY_BITS-1:0]   key;
        logic [KVT_VALUE_BITS-1:0] value;
    } t_wr;

endpackage

@@ rtl/kvt_cell.sv @@
// One table entry of the key/value table: valid bit, key and value, plus
// the register that hands the request word on to the next cell.
// Depends on kvt_pkg.
module kvt_cell
    import kvt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [KVT_IDX_W-1:0] i_index,
    input  t_tok                 i_tok,
    input  t_wr                  i_wr,
    output t_tok                 o_tok
);

    logic                      r_valid;
    logic [KVT_KEY_BITS-1:0]   r_key;
    logic [KVT_VALUE_BITS-1:0] r_value;
    t_tok                      r_tok;
    t_tok                      n_tok;
    logic                      match;
    logic                      wr_here;

    // The first valid entry with an equal key claims the request.
    assign match   = i_tok.vld && !i_tok.hit && r_valid && (r_key == i_tok.key);
    assign wr_here = i_wr.en && (i_wr.idx == i_index);

    // Update the search results carried by the word.
    always_comb begin
        n_tok = i_tok;
        if (match) begin
            n_tok.hit = 1'b1;
            if (i_tok.func == FN_GET) begin
                n_tok.rd = r_value;
            end
        end
        if (i_tok.vld && !i_tok.free_found && !r_valid) begin
            n_tok.free_found = 1'b1;
            n_tok.free_idx   = i_index;
        end
    end

    // Entry state: overwrite and delete act on a match, insert on the bus.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (wr_here) begin
            r_valid <= 1'b1;
        end else if (match && (i_tok.func == FN_DELETE)) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_here) begin
            r_key   <= i_wr.key;
            r_value <= i_wr.value;
        end else if (match && (i_tok.func == FN_PUT)) begin
            r_value <= i_tok.value;
        end
    end

    // Hand the word to the neighbor.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok.vld <= n_tok.vld;
        end
        r_tok.func       <= n_tok.func;
        r_tok.key        <= n_tok.key;
        r_tok.value      <= n_tok.value;
        r_tok.hit        <= n_tok.hit;
        r_tok.rd         <= n_tok.rd;
        r_tok.free_found <= n_tok.free_found;
        r_tok.free_idx   <= n_tok.free_idx;
    end

    assign o_tok = r_tok;

endmodule

@@ rtl/key_value_table_unit.sv @@
// Top level of the key/value table: a chain of entry cells, the result
// decision with the insert broadcast, and the output register.
// Depends on kvt_pkg and kvt_cell.
//
// Channel   Dir  Word contents (lowest bits first)
// s_axis    in   tuser: func[1:0]; tdata: key[63:0], value[127:64]
// m_axis    out  tuser: status[2:0]; tdata: read_value[63:0]
//
// A request walks the chain one cell per cycle; an insert is written in
// the cycle in which the word leaves the last cell. The next request is
// taken only after the current one is done; at most one request is in
// the chain at a time. A finished word waits in a holding
// register if the output is stalled; the next request is taken once it has
// moved to the output register. Reset is synchronous and clears all valid bits.
module key_value_table_unit
    import kvt_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [127:0]             s_axis_tdata,  // key[63:0], value[127:64]
    input  logic [KVT_FUNC_W-1:0]    s_axis_tuser,  // func[1:0]
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [KVT_VALUE_W-1:0]   m_axis_tdata,  // read_value[63:0]
    output logic [KVT_STATUS_W-1:0]  m_axis_tuser   // status[2:0]
);

    t_tok                      chain [KVT_ENTRIES+1];
    logic [KVT_ENTRIES-1:0]    chain_vld;
    t_tok                      last;
    t_wr                       wr;
    logic                      s_accept;
    logic                      out_free;
    t_status                   res_status;
    logic [KVT_VALUE_BITS-1:0] res_rd;
    logic [KVT_VALUE_W-1:0]    res_rd_ext;

    logic                      r_busy;
    logic                      r_out_vld;
    t_status                   r_out_status;
    logic [KVT_VALUE_W-1:0]    r_out_rd;
    logic                      r_pend_vld;
    t_status                   r_pend_status;
    logic [KVT_VALUE_W-1:0]    r_pend_rd;

    // Requests are taken only out of reset and while the chain is idle.
    assign s_axis_tready = !r_busy && i_rst_n;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_vld || m_axis_tready;

    // Request word entering the first cell.
    always_comb begin
        chain[0]            = '0;
        chain[0].vld        = s_accept;
        chain[0].func       = t_func'(s_axis_tuser);
        chain[0].key        = s_axis_tdata[KVT_KEY_BITS-1:0];
        chain[0].value      = s_axis_tdata[KVT_KEY_W +: KVT_VALUE_BITS];
    end

    // The cell chain, one entry per cell.
    for (genvar g = 0; g < KVT_ENTRIES; g++) begin : g_cell
        kvt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (KVT_IDX_W'(g)),
            .i_tok   (chain[g]),
            .i_wr    (wr),
            .o_tok   (chain[g+1])
        );
        assign chain_vld[g] = chain[g+1].vld;
    end

    assign last = chain[KVT_ENTRIES];

    // Final decision once the word has seen every entry.
    always_comb begin
        res_rd     = '0;
        wr         = '0;
        wr.idx     = last.free_idx;
        wr.key     = last.key;
        wr.value   = last.value;
        res_status = ST_UNKNOWN;
        case (last.func)
            FN_GET: begin
                res_status = last.hit ? ST_FOUND : ST_NOT_FOUND;
                if (last.hit) begin
                    res_rd = last.rd;
                end
            end
            FN_PUT: begin
                if (last.hit) begin
                    res_status = ST_INSERTED;
                end else if (last.free_found) begin
                    res_status = ST_INSERTED;
                    wr.en      = last.vld;
                end else begin
                    res_status = ST_FULL;
                end
            end
            FN_DELETE: begin
                res_status = last.hit ? ST_DELETED : ST_NOT_FOUND;
            end
            default: begin
                res_status = ST_UNKNOWN;
            end
        endcase
        res_rd_ext                     = '0;
        res_rd_ext[KVT_VALUE_BITS-1:0] = res_rd;
    end

    // Busy flag, holding register and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_out_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
        end else begin
            if (s_accept) begin
                r_busy <= 1'b1;
            end
            if (last.vld) begin
                if (out_free) begin
                    r_out_vld <= 1'b1;
                    r_busy    <= 1'b0;
                end else begin
                    r_pend_vld <= 1'b1;
                end
            end else if (r_pend_vld && out_free) begin
                r_out_vld  <= 1'b1;
                r_pend_vld <= 1'b0;
                r_busy     <= 1'b0;
            end else if (r_out_vld && m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (last.vld) begin
            if (out_free) begin
                r_out_status <= res_status;
                r_out_rd     <= res_rd_ext;
            end else begin
                r_pend_status <= res_status;
                r_pend_rd     <= res_rd_ext;
            end
        end else if (r_pend_vld && out_free) begin
            r_out_status <= r_pend_status;
            r_out_rd     <= r_pend_rd;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_rd;
    assign m_axis_tuser  = r_out_status;

    // At most one request is in the chain at any time.
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(chain_vld) <= 1)
        else $error("more than one request in the cell chain");

    // A new request finds the chain otherwise empty.
    a_accept_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (chain_vld == KVT_ENTRIES'(1)))
        else $error("request entered a busy chain");

    // A word in the chain belongs to an accepted, unfinished request.
    a_chain_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (chain_vld != '0) |-> r_busy)
        else $error("word in the chain while idle");

    // The holding register is used only behind a full output register.
    a_pend_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_vld |-> (r_out_vld && r_busy))
        else $error("holding register filled without a stalled output");

    // An insert is written only for a put that missed.
    a_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr.en |-> (last.vld && !last.hit && (last.func == FN_PUT)))
        else $error("insert without a missing put");

endmodule
